>>> design/tsp_pkg.sv
// ---------------------------------------------------------------------------
// tsp_pkg
// Shared constants, tables and types for the tilt-to-step-period controller.
// ---------------------------------------------------------------------------
package tsp_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ANGLE_FRAC_BITS   = 13;

	localparam int IN_W     = 16;
	localparam int IN_SHIFT = 16;
	localparam int XY_W     = IN_W + IN_SHIFT + 4;
	localparam int ANG_W    = 35;
	localparam int ITER_W   = 5;
	localparam int ROUND_SH = 30 - ANGLE_FRAC_BITS;
	localparam int TILT_W   = ANGLE_FRAC_BITS + 4;
	localparam int OUT_TILT_W = 16;

	localparam int SP_W   = 16;
	localparam int GAIN_W = 10;
	localparam int HP_W   = 14;
	localparam int ERR_W  = TILT_W + 1;
	localparam int P_W    = ERR_W - 1 + GAIN_W;
	localparam int A_W    = P_W + 5;
	localparam int SPAN_W = HP_W + 1;
	localparam int NUM_W  = A_W + SPAN_W;
	localparam int T_W    = NUM_W + 1;

	// divisor 244 * 2^F = 61 * 2^(F+2)
	localparam int DIV_ODD = 61;
	localparam int DIV_SH  = ANGLE_FRAC_BITS + 2;
	localparam longint DIV_D = longint'(DIV_ODD) << DIV_SH;
	localparam int NQ_W  = T_W + 1 - DIV_SH;
	localparam int Q_W   = HP_W;

	// n / 61 = (n * ceil(2^26 / 61)) >> 26, exact for n < 61 * 2^14
	localparam int REC_N_W = Q_W + 6;
	localparam int REC_M_W = 21;
	localparam int REC_SH  = 26;
	localparam int REC_P_W = REC_N_W + REC_M_W;
	localparam logic [REC_M_W-1:0] DIV_RECIP = 21'd1100146;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_HP   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_HP   = 2'd3;

	localparam logic signed [SP_W-1:0] SETPOINT_RST = 16'sd328;
	localparam logic [GAIN_W-1:0]      GAIN_RST     = 10'd100;
	localparam logic [HP_W-1:0]        MIN_HP_RST   = 14'd800;
	localparam logic [HP_W-1:0]        MAX_HP_RST   = 14'd5500;

	localparam logic signed [ANG_W-1:0] PI_Q30 = ANG_W'(64'd3373259426);

	typedef struct packed {
		logic                     done;
		logic signed [TILT_W-1:0] tilt;
	} cordic_res_t;

	typedef struct packed {
		logic           done;
		logic           sat;
		logic [Q_W-1:0] quot;
	} div_res_t;

	// atan(2^-i) in Q30, truncated
	function automatic logic [ANG_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
		logic [ANG_W-1:0] v;
		case (i)
			5'd0:    v = ANG_W'(64'd843314856);
			5'd1:    v = ANG_W'(64'd497837829);
			5'd2:    v = ANG_W'(64'd263043836);
			5'd3:    v = ANG_W'(64'd133525158);
			5'd4:    v = ANG_W'(64'd67021686);
			5'd5:    v = ANG_W'(64'd33543515);
			5'd6:    v = ANG_W'(64'd16775850);
			5'd7:    v = ANG_W'(64'd8388437);
			5'd8:    v = ANG_W'(64'd4194282);
			5'd9:    v = ANG_W'(64'd2097149);
			5'd10:   v = ANG_W'(64'd1048575);
			5'd11:   v = ANG_W'(64'd524287);
			5'd12:   v = ANG_W'(64'd262143);
			5'd13:   v = ANG_W'(64'd131071);
			5'd14:   v = ANG_W'(64'd65535);
			5'd15:   v = ANG_W'(64'd32767);
			5'd16:   v = ANG_W'(64'd16383);
			5'd17:   v = ANG_W'(64'd8191);
			5'd18:   v = ANG_W'(64'd4095);
			5'd19:   v = ANG_W'(64'd2047);
			5'd20:   v = ANG_W'(64'd1023);
			5'd21:   v = ANG_W'(64'd511);
			5'd22:   v = ANG_W'(64'd255);
			5'd23:   v = ANG_W'(64'd127);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> design/tsp_cordic.sv
// ---------------------------------------------------------------------------
// tsp_cordic
// Iterative vectoring CORDIC: atan2(z, y), one micro-rotation per cycle,
// then rounding of the Q30 angle to the output fraction width.
// ---------------------------------------------------------------------------
module tsp_cordic import tsp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [IN_W-1:0] y_in,
	input  logic signed [IN_W-1:0] z_in,
	output cordic_res_t            res
);

	logic signed [XY_W-1:0]   x_q, y_q;
	logic signed [ANG_W-1:0]  ang_q;
	logic [ITER_W-1:0]        i_q;
	logic                     run_q, rnd_q, zero_q, done_q;
	logic signed [TILT_W-1:0] tilt_q;

	logic signed [XY_W-1:0]  x0, y0, xs, ys;
	logic [ANG_W-1:0]        step_ang;
	logic [ANG_W-1:0]        mag, mag_r;
	logic signed [TILT_W-1:0] tilt_r;

	always_comb begin
		x0 = XY_W'(y_in) <<< IN_SHIFT;
		y0 = XY_W'(z_in) <<< IN_SHIFT;
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		step_ang = atan_q30(i_q);
		mag = ang_q[ANG_W-1] ? ANG_W'(-ang_q) : ANG_W'(ang_q);
		mag_r = (mag + (ANG_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
		tilt_r = ang_q[ANG_W-1] ? -TILT_W'(mag_r) : TILT_W'(mag_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && i_q == ITER_W'(CORDIC_ITERATIONS - 1)) begin
				run_q <= 1'b0;
				rnd_q <= 1'b1;
			end else if (rnd_q) begin
				rnd_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (y_in == '0) && (z_in == '0);
			i_q    <= '0;
			if (y_in[IN_W-1]) begin
				x_q   <= -x0;
				y_q   <= -y0;
				ang_q <= z_in[IN_W-1] ? -PI_Q30 : PI_Q30;
			end else begin
				x_q   <= x0;
				y_q   <= y0;
				ang_q <= '0;
			end
		end else if (run_q) begin
			i_q <= i_q + ITER_W'(1);
			if (!y_q[XY_W-1]) begin
				x_q   <= x_q + ys;
				y_q   <= y_q - xs;
				ang_q <= ang_q + signed'(step_ang);
			end else begin
				x_q   <= x_q - ys;
				y_q   <= y_q + xs;
				ang_q <= ang_q - signed'(step_ang);
			end
		end
		if (rnd_q) begin
			tilt_q <= zero_q ? '0 : tilt_r;
		end
	end

	assign res.done = done_q;
	assign res.tilt = tilt_q;

endmodule

>>> design/tsp_div.sv
// ---------------------------------------------------------------------------
// tsp_div
// Divide by the odd factor of the mapping divisor with a reciprocal multiply,
// quotient registered in the cycle after start, saturation flagged once the
// quotient would exceed the output width.
// ---------------------------------------------------------------------------
module tsp_div import tsp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NQ_W-1:0] dividend,
	output div_res_t        res
);

	logic [REC_P_W-1:0] prod_q;
	logic               done_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q  <= dividend >= (NQ_W'(DIV_ODD) << Q_W);
			prod_q <= REC_P_W'(dividend[REC_N_W-1:0]) * REC_P_W'(DIV_RECIP);
		end
	end

	assign res.done = done_q;
	assign res.sat  = sat_q;
	assign res.quot = prod_q[REC_SH +: Q_W];

endmodule

>>> design/tilt_to_step_period_controller.sv
// ---------------------------------------------------------------------------
// tilt_to_step_period_controller
// Accelerometer Y/Z sample in, stepper direction, filtered half-period and
// tilt out. One sample at a time; result held in an output register.
// ---------------------------------------------------------------------------
// An input beat is followed by the CORDIC micro-rotations, a rounding step,
// the error, gain and mapping arithmetic states with one multiplier per cycle,
// the reciprocal multiply for the divide, the hand-off of the quotient into
// the output register, and then the result beat. in_ready is high only while
// the block is idle, which it is again once the result is loaded, so a new
// sample is not taken before the previous result is loaded; a new sample may
// be taken while the previous result still waits on out_ready.
// The half-period filter state resets to zero.
module tilt_to_step_period_controller import tsp_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [IN_W-1:0]       accel_y,
	input  logic signed [IN_W-1:0]       accel_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         direction,
	output logic [HP_W-1:0]              half_period_us,
	output logic signed [OUT_TILT_W-1:0] tilt_angle,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]             cfg_data
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CORDIC = 4'd1;
	localparam logic [3:0] S_ERR    = 4'd2;
	localparam logic [3:0] S_MUL    = 4'd3;
	localparam logic [3:0] S_A      = 4'd4;
	localparam logic [3:0] S_NUM    = 4'd5;
	localparam logic [3:0] S_T      = 4'd6;
	localparam logic [3:0] S_PREP   = 4'd7;
	localparam logic [3:0] S_DIV    = 4'd8;
	localparam logic [3:0] S_DONE   = 4'd9;

	logic [3:0] state_q;

	logic signed [SP_W-1:0] setpoint_q;
	logic [GAIN_W-1:0]      gain_q;
	logic [HP_W-1:0]        min_q, max_q;

	logic signed [TILT_W-1:0] tilt_q;
	logic signed [ERR_W-1:0]  err_q;
	logic [P_W-1:0]           p_q;
	logic signed [A_W-1:0]    a_q;
	logic signed [SPAN_W-1:0] span_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [T_W-1:0]    t_q;
	logic                     neg_q;

	logic                     out_valid_q, dir_q;
	logic [HP_W-1:0]          half_q;
	logic signed [OUT_TILT_W-1:0] tilt_out_q;

	cordic_res_t cordic_res;
	div_res_t    div_res;

	logic                    in_beat, load_out, div_start;
	logic [ERR_W-2:0]        err_mag;
	logic [A_W-1:0]          p_ext;
	logic [T_W-1:0]          mxd;
	logic [T_W:0]            t_sum;
	logic [NQ_W-1:0]         nq;
	logic [HP_W-1:0]         q_hi, q_c;
	logic [HP_W:0]           avg_sum;

	assign in_beat   = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign div_start = (state_q == S_PREP);

	always_comb begin
		err_mag = err_q[ERR_W-1] ? (ERR_W-1)'(-err_q) : (ERR_W-1)'(err_q);
		p_ext   = A_W'(p_q);
		mxd     = T_W'(max_q) * T_W'(DIV_D);
		t_sum   = {1'b0, t_q} + (T_W+1)'(DIV_D / 2);
		nq      = t_sum[T_W:DIV_SH];
		q_hi    = (div_res.sat || div_res.quot > max_q) ? max_q : div_res.quot;
		if (neg_q || q_hi < min_q) begin
			q_c = min_q;
		end else begin
			q_c = q_hi;
		end
		avg_sum = (HP_W+1)'(q_c) + (HP_W+1)'(half_q);
	end

	tsp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_beat),
		.y_in   (accel_y),
		.z_in   (accel_z),
		.res    (cordic_res)
	);

	tsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nq),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SETPOINT_RST;
			gain_q     <= GAIN_RST;
			min_q      <= MIN_HP_RST;
			max_q      <= MAX_HP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETPOINT: setpoint_q <= signed'(cfg_data[SP_W-1:0]);
				REG_GAIN:     gain_q     <= cfg_data[GAIN_W-1:0];
				REG_MIN_HP:   min_q      <= cfg_data[HP_W-1:0];
				REG_MAX_HP:   max_q      <= cfg_data[HP_W-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			half_q      <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				half_q      <= avg_sum[HP_W:1];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE:   if (in_beat) begin
					state_q <= S_CORDIC;
				end
				S_CORDIC: if (cordic_res.done) begin
					state_q <= S_ERR;
				end
				S_ERR:    state_q <= S_MUL;
				S_MUL:    state_q <= S_A;
				S_A:      state_q <= S_NUM;
				S_NUM:    state_q <= S_T;
				S_T:      state_q <= S_PREP;
				S_PREP:   state_q <= S_DIV;
				S_DIV:    if (div_res.done) begin
					state_q <= S_DONE;
				end
				S_DONE:   if (load_out) begin
					state_q <= S_IDLE;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CORDIC && cordic_res.done) begin
			tilt_q <= cordic_res.tilt;
			err_q  <= ERR_W'(setpoint_q) - ERR_W'(cordic_res.tilt);
		end
		if (state_q == S_MUL) begin
			p_q <= P_W'(err_mag) * P_W'(gain_q);
		end
		if (state_q == S_A) begin
			a_q    <= signed'((p_ext << 3) + (p_ext << 1)
				- (A_W'(6) << ANGLE_FRAC_BITS));
			span_q <= signed'(SPAN_W'(max_q) - SPAN_W'(min_q));
		end
		if (state_q == S_NUM) begin
			num_q <= NUM_W'(a_q) * NUM_W'(span_q);
		end
		if (state_q == S_T) begin
			t_q <= signed'(mxd) - T_W'(num_q);
		end
		if (state_q == S_PREP) begin
			neg_q <= t_q[T_W-1];
		end
		if (load_out) begin
			dir_q      <= !err_q[ERR_W-1];
			tilt_out_q <= tilt_q[OUT_TILT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign direction      = dir_q;
	assign half_period_us = half_q;
	assign tilt_angle     = tilt_out_q;

`ifndef ASSERT_OFF
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("input taken while busy");

	a_cordic_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_res.done |-> state_q == S_CORDIC)
		else $error("cordic done outside cordic state");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid && state_q == S_IDLE)
		else $error("result load did not raise out_valid");
`endif

endmodule
